[design/lts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, token codes, character codes and keyword tables for the
// lexical token scanner.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int TokLenW     = 5;
    localparam int MaxTokenLen = 31;
    localparam int LineW       = 16;
    localparam int KwCount     = 11;

    localparam logic [LineW-1:0]   LineMax = {LineW{1'b1}};
    localparam logic [KwCount-1:0] KwAll   = {KwCount{1'b1}};

    // token codes
    localparam logic [4:0] TokNone    = 5'd0;
    localparam logic [4:0] TokIdent   = 5'd12;
    localparam logic [4:0] TokInt     = 5'd13;
    localparam logic [4:0] TokLe      = 5'd14;
    localparam logic [4:0] TokNe      = 5'd15;
    localparam logic [4:0] TokLt      = 5'd16;
    localparam logic [4:0] TokAssign  = 5'd17;
    localparam logic [4:0] TokColon   = 5'd18;
    localparam logic [4:0] TokGe      = 5'd19;
    localparam logic [4:0] TokGt      = 5'd20;
    localparam logic [4:0] TokPlus    = 5'd21;
    localparam logic [4:0] TokMinus   = 5'd22;
    localparam logic [4:0] TokStar    = 5'd23;
    localparam logic [4:0] TokSemi    = 5'd24;
    localparam logic [4:0] TokBar     = 5'd25;
    localparam logic [4:0] TokCmtOpen = 5'd26;
    localparam logic [4:0] TokCmtEnd  = 5'd27;
    localparam logic [4:0] TokLParen  = 5'd28;
    localparam logic [4:0] TokRParen  = 5'd29;
    localparam logic [4:0] TokComma   = 5'd30;
    localparam logic [4:0] TokPeriod  = 5'd31;

    // error kinds
    localparam logic [1:0] ErrNone    = 2'd0;
    localparam logic [1:0] ErrAlphaNum = 2'd1;
    localparam logic [1:0] ErrBadChar = 2'd2;

    // input commands
    localparam logic CmdChar  = 1'b0;
    localparam logic CmdFlush = 1'b1;

    // characters
    localparam logic [7:0] ChLt     = 8'h3C;
    localparam logic [7:0] ChGt     = 8'h3E;
    localparam logic [7:0] ChColon  = 8'h3A;
    localparam logic [7:0] ChEq     = 8'h3D;
    localparam logic [7:0] ChStar   = 8'h2A;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChPlus   = 8'h2B;
    localparam logic [7:0] ChMinus  = 8'h2D;
    localparam logic [7:0] ChSemi   = 8'h3B;
    localparam logic [7:0] ChBar    = 8'h7C;
    localparam logic [7:0] ChLParen = 8'h28;
    localparam logic [7:0] ChRParen = 8'h29;
    localparam logic [7:0] ChComma  = 8'h2C;
    localparam logic [7:0] ChPeriod = 8'h2E;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChNl     = 8'h0A;

    typedef enum logic [9:0] {
        M_IDLE    = 10'b00_0000_0001,
        M_IDENT   = 10'b00_0000_0010,
        M_INT     = 10'b00_0000_0100,
        M_LT      = 10'b00_0000_1000,
        M_COLON   = 10'b00_0001_0000,
        M_GT      = 10'b00_0010_0000,
        M_STAR    = 10'b00_0100_0000,
        M_SLASH   = 10'b00_1000_0000,
        M_COMMENT = 10'b01_0000_0000,
        M_CSTAR   = 10'b10_0000_0000
    } t_mode;

    typedef struct packed {
        logic [4:0]         code;
        logic [1:0]         err;
        logic [TokLenW-1:0] len;
        logic [LineW-1:0]   line;
        logic               last;
    } t_result;

    // reserved words, right-aligned text packed into the low bytes (last character in the lowest byte)
    function automatic logic [63:0] kw_word(input int unsigned k);
        logic [63:0] s;
        begin
            case (k)
                0:       s = 64'("else if");
                1:       s = 64'("void");
                2:       s = 64'("if");
                3:       s = 64'("int");
                4:       s = 64'("else");
                5:       s = 64'("for");
                6:       s = 64'("do");
                7:       s = 64'("while");
                8:       s = 64'("return");
                9:       s = 64'("switch");
                default: s = 64'("case");
            endcase
            return s;
        end
    endfunction

    function automatic logic [3:0] kw_len(input int unsigned k);
        logic [3:0] n;
        begin
            case (k)
                0:       n = 4'd7;
                1:       n = 4'd4;
                2:       n = 4'd2;
                3:       n = 4'd3;
                4:       n = 4'd4;
                5:       n = 4'd3;
                6:       n = 4'd2;
                7:       n = 4'd5;
                8:       n = 4'd6;
                9:       n = 4'd6;
                default: n = 4'd4;
            endcase
            return n;
        end
    endfunction

    // drop every word that has no character at pos or whose character at pos differs from ch
    function automatic logic [KwCount-1:0] kw_step(input logic [KwCount-1:0] mask,
                                                   input logic [TokLenW-1:0] pos,
                                                   input logic [7:0] ch);
        logic [KwCount-1:0] m;
        logic [63:0]        w;
        logic [3:0]         n;
        int unsigned        sh;
        begin
            m = mask;
            for (int unsigned k = 0; k < KwCount; k++) begin
                w  = kw_word(k);
                n  = kw_len(k);
                sh = 0;
                if (pos < TokLenW'(n)) begin
                    sh = 8 * (int'(n) - 1 - int'(pos));
                end
                if (!(pos < TokLenW'(n) && w[sh +: 8] == ch)) begin
                    m[k] = 1'b0;
                end
            end
            return m;
        end
    endfunction

    // whole-token match, lowest word index wins
    function automatic logic [4:0] kw_code(input logic [KwCount-1:0] mask,
                                           input logic [TokLenW-1:0] cnt);
        logic [4:0] c;
        begin
            c = TokIdent;
            for (int k = KwCount - 1; k >= 0; k--) begin
                if (mask[k] && TokLenW'(kw_len(k)) == cnt) begin
                    c = 5'(k + 1);
                end
            end
            return c;
        end
    endfunction

endpackage

[design/lexical_token_scanner_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexical_token_scanner_top
// Character-stream tokenizer: classifies identifiers, reserved words,
// integers, operators and comments and emits one result per token or error.
//
//   channel  direction  handshake               payload
//   input    in         i_valid / o_stall       i_command, i_char_code
//   output   out        o_valid / i_stall       o_token_code, o_error_kind,
//                                               o_token_length, o_line_number,
//                                               o_last_result
//
// One request is registered, then classified combinationally; its zero,
// one or two results enter a four-entry result queue.
// A new request is taken every cycle while the queue keeps room for two
// results; a request's two results leave the queue one after the other.
// Reset is synchronous: idle mode, empty queue, line one.
// Output stall backs up through the registered queue count to o_stall.
// ----------------------------------------------------------------------------
module lexical_token_scanner_top
    import lts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic [7:0]         i_char_code,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [4:0]         o_token_code,
    output logic [1:0]         o_error_kind,
    output logic [TokLenW-1:0] o_token_length,
    output logic [LineW-1:0]   o_line_number,
    output logic               o_last_result
);

    logic               r_in_valid;
    logic               r_cmd;
    logic [7:0]         r_char;

    t_mode              r_mode,  n_mode;
    logic [TokLenW-1:0] r_tcnt,  n_tcnt;
    logic [KwCount-1:0] r_kmask, n_kmask;
    logic [LineW-1:0]   r_line,  n_line;

    t_result            r_fifo [4];
    logic [1:0]         r_wr, r_rd;
    logic [2:0]         r_count;

    t_result            slot0, slot1;
    logic [1:0]         push_cnt;
    logic               accept, pop;

    // character classes
    logic               is_alpha, is_digit, is_alnum;
    logic [7:0]         c_low;
    logic [TokLenW-1:0] tcnt_inc;
    logic [KwCount-1:0] kmask_cont, kmask_new;
    logic [4:0]         ident_code;

    // idle-mode handling of the current character
    t_mode              id_mode;
    logic [TokLenW-1:0] id_tcnt;
    logic [KwCount-1:0] id_kmask;
    logic               id_nl, id_v;
    logic [4:0]         id_code;
    logic [1:0]         id_err;
    logic [TokLenW-1:0] id_len;

    // first-pass results
    logic               pa_v, pb_v, again, line_inc;
    logic [4:0]         pa_code, pb_code;
    logic [1:0]         pa_err;
    logic [TokLenW-1:0] pa_len, pb_len;

    assign accept = i_valid && !o_stall;
    assign pop    = o_valid && !i_stall;

    // hold input while the request in flight could overfill the queue
    assign o_stall = ({1'b0, r_count} + {2'b00, push_cnt}) > 4'd2;

    assign is_alpha = (r_char >= 8'h61 && r_char <= 8'h7A) ||
                      (r_char >= 8'h41 && r_char <= 8'h5A);
    assign is_digit = r_char >= 8'h30 && r_char <= 8'h39;
    assign is_alnum = is_alpha || is_digit;
    assign c_low    = (r_char >= 8'h41 && r_char <= 8'h5A) ? r_char + 8'h20 : r_char;
    assign tcnt_inc = (r_tcnt < TokLenW'(MaxTokenLen)) ? r_tcnt + 1'b1 : r_tcnt;

    assign kmask_cont = kw_step(r_kmask, r_tcnt, c_low);
    assign kmask_new  = kw_step(KwAll, '0, c_low);
    assign ident_code = kw_code(r_kmask, r_tcnt);

    always_comb begin
        id_mode  = M_IDLE;
        id_tcnt  = '0;
        id_kmask = KwAll;
        id_nl    = 1'b0;
        id_v     = 1'b0;
        id_code  = TokNone;
        id_err   = ErrNone;
        id_len   = TokLenW'(1);
        if (is_alpha) begin
            id_mode  = M_IDENT;
            id_tcnt  = TokLenW'(1);
            id_kmask = kmask_new;
        end else if (is_digit) begin
            id_mode = M_INT;
            id_tcnt = TokLenW'(1);
        end else begin
            case (r_char)
                ChLt:     id_mode = M_LT;
                ChColon:  id_mode = M_COLON;
                ChGt:     id_mode = M_GT;
                ChStar:   id_mode = M_STAR;
                ChSlash:  id_mode = M_SLASH;
                ChPlus:   begin id_v = 1'b1; id_code = TokPlus;    end
                ChMinus:  begin id_v = 1'b1; id_code = TokMinus;   end
                ChSemi:   begin id_v = 1'b1; id_code = TokSemi;    end
                ChBar:    begin id_v = 1'b1; id_code = TokBar;     end
                ChLParen: begin id_v = 1'b1; id_code = TokLParen;  end
                ChRParen: begin id_v = 1'b1; id_code = TokRParen;  end
                ChComma:  begin id_v = 1'b1; id_code = TokComma;   end
                ChPeriod: begin id_v = 1'b1; id_code = TokPeriod;  end
                ChSpace, ChTab: ;
                ChNl:     id_nl = 1'b1;
                default: begin
                    id_v   = 1'b1;
                    id_err = ErrBadChar;
                    id_len = '0;
                end
            endcase
        end
    end

    // mode step: first-pass result(s), then optional re-scan from idle
    always_comb begin
        n_mode   = r_mode;
        n_tcnt   = r_tcnt;
        n_kmask  = r_kmask;
        pa_v     = 1'b0;
        pa_code  = TokNone;
        pa_err   = ErrNone;
        pa_len   = '0;
        pb_v     = 1'b0;
        pb_code  = TokInt;
        pb_len   = r_tcnt;
        again    = 1'b0;
        line_inc = 1'b0;
        if (r_cmd == CmdFlush) begin
            unique case (r_mode)
                M_IDENT: begin pa_v = 1'b1; pa_code = ident_code; pa_len = r_tcnt; end
                M_INT:   begin pa_v = 1'b1; pa_code = TokInt;     pa_len = r_tcnt; end
                M_LT:    begin pa_v = 1'b1; pa_code = TokLt;    pa_len = TokLenW'(1); end
                M_COLON: begin pa_v = 1'b1; pa_code = TokColon; pa_len = TokLenW'(1); end
                M_GT:    begin pa_v = 1'b1; pa_code = TokGt;    pa_len = TokLenW'(1); end
                M_STAR:  begin pa_v = 1'b1; pa_code = TokStar;  pa_len = TokLenW'(1); end
                default: ;
            endcase
            n_mode  = M_IDLE;
            n_tcnt  = '0;
            n_kmask = KwAll;
        end else begin
            unique case (r_mode)
                M_IDENT: begin
                    if (is_alnum) begin
                        n_tcnt  = tcnt_inc;
                        n_kmask = kmask_cont;
                    end else begin
                        pa_v    = 1'b1;
                        pa_code = ident_code;
                        pa_len  = r_tcnt;
                        again   = 1'b1;
                    end
                end
                M_INT: begin
                    if (is_digit) begin
                        n_tcnt = tcnt_inc;
                    end else if (is_alpha) begin
                        // error first, then the integer itself
                        pa_v   = 1'b1;
                        pa_err = ErrAlphaNum;
                        pb_v   = 1'b1;
                        again  = 1'b1;
                    end else begin
                        pa_v    = 1'b1;
                        pa_code = TokInt;
                        pa_len  = r_tcnt;
                        again   = 1'b1;
                    end
                end
                M_LT: begin
                    pa_v    = 1'b1;
                    pa_len  = TokLenW'(2);
                    if (r_char == ChEq) begin
                        pa_code = TokLe;
                    end else if (r_char == ChGt) begin
                        pa_code = TokNe;
                    end else begin
                        pa_code = TokLt;
                        pa_len  = TokLenW'(1);
                        again   = 1'b1;
                    end
                    n_mode = M_IDLE;
                end
                M_COLON, M_GT, M_STAR: begin
                    pa_v = 1'b1;
                    if (r_mode == M_STAR && r_char == ChSlash) begin
                        pa_code = TokCmtEnd;
                        pa_len  = TokLenW'(2);
                    end else if (r_mode != M_STAR && r_char == ChEq) begin
                        pa_code = (r_mode == M_COLON) ? TokAssign : TokGe;
                        pa_len  = TokLenW'(2);
                    end else begin
                        pa_code = (r_mode == M_COLON) ? TokColon :
                                  (r_mode == M_GT)    ? TokGt    : TokStar;
                        pa_len  = TokLenW'(1);
                        again   = 1'b1;
                    end
                    n_mode = M_IDLE;
                end
                M_SLASH: begin
                    if (r_char == ChStar) begin
                        pa_v    = 1'b1;
                        pa_code = TokCmtOpen;
                        pa_len  = TokLenW'(2);
                        n_mode  = M_COMMENT;
                    end else begin
                        again = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (r_char == ChStar) begin
                        n_mode = M_CSTAR;
                    end else if (r_char == ChNl) begin
                        line_inc = 1'b1;
                    end
                end
                M_CSTAR: begin
                    if (r_char == ChSlash) begin
                        pa_v    = 1'b1;
                        pa_code = TokCmtEnd;
                        pa_len  = TokLenW'(2);
                        n_mode  = M_IDLE;
                    end else if (r_char != ChStar) begin
                        line_inc = r_char == ChNl;
                        n_mode   = M_COMMENT;
                    end
                end
                default: again = 1'b1;
            endcase
            if (again) begin
                n_mode   = id_mode;
                n_tcnt   = id_tcnt;
                n_kmask  = id_kmask;
                line_inc = id_nl;
            end
        end
    end

    assign n_line = (line_inc && r_line != LineMax) ? r_line + 1'b1 : r_line;

    // pack up to two results in order
    always_comb begin
        slot0    = '{code: pa_code, err: pa_err, len: pa_len, line: r_line, last: 1'b0};
        slot1    = '{code: pb_code, err: ErrNone, len: pb_len, line: r_line, last: 1'b1};
        push_cnt = 2'd0;
        if (r_in_valid && r_cmd == CmdChar) begin
            if (pa_v && pb_v) begin
                push_cnt = 2'd2;
            end else if (pa_v && again && id_v) begin
                slot1    = '{code: id_code, err: id_err, len: id_len, line: r_line,
                             last: 1'b1};
                push_cnt = 2'd2;
            end else if (pa_v) begin
                slot0.last = 1'b1;
                push_cnt   = 2'd1;
            end else if (again && id_v) begin
                slot0    = '{code: id_code, err: id_err, len: id_len, line: r_line,
                             last: 1'b1};
                push_cnt = 2'd1;
            end
        end else if (r_in_valid && pa_v) begin
            slot0.last = 1'b1;
            push_cnt   = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_tcnt     <= '0;
            r_kmask    <= KwAll;
            r_line     <= LineW'(1);
            r_wr       <= '0;
            r_rd       <= '0;
            r_count    <= '0;
        end else begin
            r_in_valid <= accept;
            if (r_in_valid) begin
                r_mode  <= n_mode;
                r_tcnt  <= n_tcnt;
                r_kmask <= n_kmask;
                r_line  <= n_line;
            end
            r_wr    <= r_wr + push_cnt;
            r_rd    <= r_rd + {1'b0, pop};
            r_count <= r_count + {1'b0, push_cnt} - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_command;
            r_char <= i_char_code;
        end
        if (push_cnt != 2'd0) begin
            r_fifo[r_wr] <= slot0;
        end
        if (push_cnt == 2'd2) begin
            r_fifo[r_wr + 2'd1] <= slot1;
        end
    end

    assign o_valid        = r_count != 3'd0;
    assign o_token_code   = r_fifo[r_rd].code;
    assign o_error_kind   = r_fifo[r_rd].err;
    assign o_token_length = r_fifo[r_rd].len;
    assign o_line_number  = r_fifo[r_rd].line;
    assign o_last_result  = r_fifo[r_rd].last;

endmodule

[design/lts_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_checker
// Port-level checks on the scanner's result stream.
// ----------------------------------------------------------------------------
module lts_checker
    import lts_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [4:0]         o_token_code,
    input logic [1:0]         o_error_kind,
    input logic [TokLenW-1:0] o_token_length,
    input logic [LineW-1:0]   o_line_number,
    input logic               o_last_result
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_code) &&
        $stable(o_line_number) && $stable(o_last_result))
        else $error("stalled result changed");

    // error-only results carry no token and no length
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_kind != ErrNone |->
        o_token_code == TokNone && o_token_length == '0)
        else $error("error result carries a token");

    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_code == TokNone |-> o_error_kind != ErrNone)
        else $error("code zero without an error");

    // a letter-after-integer error is never the last result of its request; the integer token follows it
    a_err_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_kind == ErrAlphaNum |-> !o_last_result)
        else $error("letter-after-integer error closes a request");

    a_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_line_number != '0)
        else $error("line number zero");

endmodule

bind lexical_token_scanner_top lts_checker u_lts_checker (.*);
